// ===== sv/lattice_species_move_reproduce_unit_defines.svh =====
// Assertion macros shared by the lattice species unit checker.
// Depends on nothing; the user must have clk and arst_n in scope.
`ifndef LATTICE_SPECIES_MOVE_REPRODUCE_UNIT_DEFINES_SVH
`define LATTICE_SPECIES_MOVE_REPRODUCE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define LSMR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsmr check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define LSMR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsmr check failed");

`endif

// ===== sv/lsmr_pkg.sv =====
// Shared types, field widths and codes of the lattice species unit.
// Depends on nothing; used by lsmr_addr, the top level and lsmr_chk.
package lsmr_pkg;

	// Field widths
	localparam int ROW_W      = 9;
	localparam int COL_W      = 9;
	localparam int DRAW_W     = 16;
	localparam int SP_W       = 4;
	localparam int CH_W       = 8;
	localparam int EV_W       = 3;
	localparam int MODE_W     = 2;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// Number of live species; ids run 1..SPECIES
	localparam int SPECIES = 3;
	localparam logic [CH_W-1:0] LIVE_MASK = CH_W'((1 << SPECIES) - 1);

	// Input modes
	localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	// Result events
	localparam logic [EV_W-1:0] EV_IDLE    = 3'd0;
	localparam logic [EV_W-1:0] EV_DIED    = 3'd1;
	localparam logic [EV_W-1:0] EV_MOVED   = 3'd2;
	localparam logic [EV_W-1:0] EV_REPRO   = 3'd3;
	localparam logic [EV_W-1:0] EV_WRITTEN = 3'd4;
	localparam logic [EV_W-1:0] EV_READ    = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEATH_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NEED_MATRIX     = 2'd1;

	localparam logic [DRAW_W-1:0] THR_RESET = 16'd6554;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_HERE,
		ST_CHK_HERE,
		ST_EVAL,
		ST_WR_HERE,
		ST_FIN
	} state_t;

	// One lattice site as stored in memory
	typedef struct packed {
		logic [CH_W-1:0] chem;
		logic [SP_W-1:0] species;
	} site_t;

	localparam site_t SITE_RESET = '{chem: 8'hFF, species: 4'h0};

	// Coordinate request handed to the address unit
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             axis;
		logic             step_sign;
	} addr_req_t;

	// One result item
	typedef struct packed {
		logic [EV_W-1:0] ev;
		logic [SP_W-1:0] site_species;
		logic [SP_W-1:0] neighbour_species;
		logic [CH_W-1:0] site_chemicals;
	} result_t;

endpackage

// ===== sv/lsmr_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module lsmr_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 262144,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write first in program order, read returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/lsmr_addr.sv =====
// Address unit: wraps row/col onto the torus, finds the neighbour and
// registers both memory addresses. Depends on lsmr_pkg.
module lsmr_addr #(
	parameter int SIDE = 512,
	localparam int CW = $clog2(SIDE),
	localparam int AW = $clog2(SIDE * SIDE)
) (
	input  logic                 clk,
	input  logic                 load,
	input  lsmr_pkg::addr_req_t  req,
	output logic [AW-1:0]        here_addr,
	output logic [AW-1:0]        there_addr
);

	localparam int RW   = (CW > lsmr_pkg::ROW_W) ? CW : lsmr_pkg::ROW_W;
	localparam int SPAN = 1 << lsmr_pkg::ROW_W;

	logic [CW-1:0] r_w, c_w, nr_w, nc_w, r_nb, c_nb;
	logic [AW-1:0] here_q, there_q;

	// Reduce a 9-bit coordinate modulo SIDE by shifted compare/subtract
	function automatic logic [CW-1:0] wrap_coord(input logic [lsmr_pkg::ROW_W-1:0] v_in);
		logic [RW-1:0] v;
		v = RW'(v_in);
		for (int k = lsmr_pkg::ROW_W - 1; k >= 0; k--) begin
			if ((SIDE << k) < SPAN) begin
				if (v >= RW'(SIDE << k)) begin
					v = v - RW'(SIDE << k);
				end
			end
		end
		return CW'(v);
	endfunction

	// One wrapped step up or down
	function automatic logic [CW-1:0] step_coord(input logic [CW-1:0] v, input logic up);
		logic [CW-1:0] res;
		if (up) begin
			res = (v == CW'(SIDE - 1)) ? '0 : v + CW'(1);
		end else begin
			res = (v == '0) ? CW'(SIDE - 1) : v - CW'(1);
		end
		return res;
	endfunction

	function automatic logic [AW-1:0] site_index(input logic [CW-1:0] r, input logic [CW-1:0] c);
		return AW'(AW'(r) * AW'(SIDE)) + AW'(c);
	endfunction

	assign r_w  = wrap_coord(req.row);
	assign c_w  = wrap_coord(req.col);
	assign r_nb = step_coord(r_w, req.step_sign);
	assign c_nb = step_coord(c_w, req.step_sign);
	assign nr_w = req.axis ? r_w : r_nb;
	assign nc_w = req.axis ? c_nb : c_w;

	// Address registers, loaded with each transaction
	always_ff @(posedge clk) begin
		if (load) begin
			here_q  <= site_index(r_w, c_w);
			there_q <= site_index(nr_w, nc_w);
		end
	end

	assign here_addr  = here_q;
	assign there_addr = there_q;

endmodule

// ===== sv/lattice_species_move_reproduce_unit.sv =====
// Write items pass RD_HERE and FIN; read, empty-site, death and unused-mode items
// pass RD_HERE, CHK_HERE and FIN; a move passes EVAL and WR_HERE before FIN too.
// One item is in work at a time, and FIN waits for a free output register. The
// lattice memory has one read and one write port (two reads and two writes per
// move), so a move needs EVAL and WR_HERE. After arst_n the lattice is swept to
// SIDE*SIDE (262144 at SIDE=512) empty sites with all chemicals; no input is taken.
module lattice_species_move_reproduce_unit #(
	parameter int SIDE = 512
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// row[8:0], col[17:9], death_draw[33:18], axis_select[34], step_sign[35],
	// write_species[39:36], write_chemicals[47:40]
	input  logic [lsmr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
	// mode[1:0]
	input  logic [lsmr_pkg::MODE_W-1:0]         s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// site_species[3:0], neighbour_species[7:4], site_chemicals[15:8]
	output logic [lsmr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// event_res[2:0]
	output logic [lsmr_pkg::EV_W-1:0]           m_axis_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lsmr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsmr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DEPTH = SIDE * SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int SW    = $bits(lsmr_pkg::site_t);

	lsmr_pkg::state_t state_q, state_d;

	logic                          s_accept;
	lsmr_pkg::addr_req_t           req;
	logic [AW-1:0]                 here_addr, there_addr;
	logic [AW-1:0]                 clr_q;

	logic [lsmr_pkg::MODE_W-1:0]   mode_q;
	logic [lsmr_pkg::DRAW_W-1:0]   draw_q;
	logic [lsmr_pkg::SP_W-1:0]     wsp_q;
	logic [lsmr_pkg::CH_W-1:0]     wch_q;
	logic [lsmr_pkg::DRAW_W-1:0]   thr_q;
	logic [lsmr_pkg::CFG_DATA_W-1:0] need_q;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	lsmr_pkg::site_t               ram_wdata, ram_rdata;
	logic [SW-1:0]                 ram_rdata_raw;

	lsmr_pkg::site_t               here_site_q;
	logic [lsmr_pkg::SP_W-1:0]     here_new_q;
	lsmr_pkg::result_t             res_q, out_q;
	logic                          out_valid_q;

	logic [lsmr_pkg::SP_W-1:0]     wsp_clamped;
	logic                          is_update, site_empty, dies, out_free;
	logic [2:0]                    sp_idx;
	logic [lsmr_pkg::CH_W-1:0]     need, own_bit, chem_marked, chem_there;
	logic                          repro;
	logic [lsmr_pkg::SP_W-1:0]     here_new;

	assign s_accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_axis_tready;

	assign req = '{
		row:       s_axis_tdata[8:0],
		col:       s_axis_tdata[17:9],
		axis:      s_axis_tdata[34],
		step_sign: s_axis_tdata[35]
	};

	lsmr_addr #(.SIDE(SIDE)) u_addr (
		.clk        (clk),
		.load       (s_accept),
		.req        (req),
		.here_addr  (here_addr),
		.there_addr (there_addr)
	);

	lsmr_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = ram_rdata_raw;

	// Decode of the site just read and of the move outcome
	assign wsp_clamped = (wsp_q <= lsmr_pkg::SP_W'(lsmr_pkg::SPECIES)) ? wsp_q : '0;
	assign is_update   = (mode_q == lsmr_pkg::MODE_UPDATE);
	assign site_empty  = (ram_rdata.species == '0);
	assign dies        = (draw_q < thr_q);
	assign sp_idx      = 3'(here_site_q.species - lsmr_pkg::SP_W'(1));
	assign need        = need_q[{sp_idx, 3'b000} +: lsmr_pkg::CH_W] & lsmr_pkg::LIVE_MASK;
	assign own_bit     = lsmr_pkg::CH_W'(1) << sp_idx;
	assign chem_marked = ram_rdata.chem | own_bit;
	assign repro       = (ram_rdata.species == '0) && ((chem_marked & need) == need);
	assign chem_there  = repro ? (chem_marked & ~need) : chem_marked;
	assign here_new    = repro ? here_site_q.species : ram_rdata.species;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lsmr_pkg::ST_CLEAR: begin
				if (clr_q == AW'(DEPTH - 1)) state_d = lsmr_pkg::ST_IDLE;
			end
			lsmr_pkg::ST_IDLE: begin
				if (s_accept) state_d = lsmr_pkg::ST_RD_HERE;
			end
			lsmr_pkg::ST_RD_HERE: begin
				state_d = (mode_q == lsmr_pkg::MODE_WRITE) ? lsmr_pkg::ST_FIN
				                                           : lsmr_pkg::ST_CHK_HERE;
			end
			lsmr_pkg::ST_CHK_HERE: begin
				state_d = (is_update && !site_empty && !dies) ? lsmr_pkg::ST_EVAL
				                                              : lsmr_pkg::ST_FIN;
			end
			lsmr_pkg::ST_EVAL:    state_d = lsmr_pkg::ST_WR_HERE;
			lsmr_pkg::ST_WR_HERE: state_d = lsmr_pkg::ST_FIN;
			lsmr_pkg::ST_FIN: begin
				if (out_free) state_d = lsmr_pkg::ST_IDLE;
			end
			default: state_d = lsmr_pkg::ST_IDLE;
		endcase
	end

	// Memory control and input ready
	always_comb begin
		ram_we        = 1'b0;
		ram_waddr     = here_addr;
		ram_wdata     = lsmr_pkg::SITE_RESET;
		ram_raddr     = here_addr;
		s_axis_tready = 1'b0;
		case (state_q)
			lsmr_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			lsmr_pkg::ST_IDLE: s_axis_tready = 1'b1;
			lsmr_pkg::ST_RD_HERE: begin
				if (mode_q == lsmr_pkg::MODE_WRITE) begin
					ram_we    = 1'b1;
					ram_wdata = '{chem: wch_q, species: wsp_clamped};
				end
			end
			lsmr_pkg::ST_CHK_HERE: begin
				ram_raddr = there_addr;
				if (is_update && !site_empty && dies) begin
					ram_we    = 1'b1;
					ram_wdata = '{chem: ram_rdata.chem, species: '0};
				end
			end
			lsmr_pkg::ST_EVAL: begin
				ram_we    = 1'b1;
				ram_waddr = there_addr;
				ram_wdata = '{chem: chem_there, species: here_site_q.species};
			end
			lsmr_pkg::ST_WR_HERE: begin
				ram_we    = 1'b1;
				ram_wdata = '{chem: here_site_q.chem, species: here_new_q};
			end
			default: ;
		endcase
	end

	// Control state: FSM, clear sweep, configuration, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsmr_pkg::ST_CLEAR;
			clr_q       <= '0;
			thr_q       <= lsmr_pkg::THR_RESET;
			need_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lsmr_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lsmr_pkg::CFG_DEATH_THRESHOLD: thr_q  <= cfg_data[lsmr_pkg::DRAW_W-1:0];
					lsmr_pkg::CFG_NEED_MATRIX:     need_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == lsmr_pkg::ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item payload, read-back data and result assembly
	always_ff @(posedge clk) begin
		if (s_accept) begin
			mode_q <= s_axis_tuser;
			draw_q <= s_axis_tdata[33:18];
			wsp_q  <= s_axis_tdata[39:36];
			wch_q  <= s_axis_tdata[47:40];
		end
		case (state_q)
			lsmr_pkg::ST_RD_HERE: begin
				res_q <= '{ev: lsmr_pkg::EV_WRITTEN, site_species: wsp_clamped,
				           neighbour_species: '0, site_chemicals: '0};
			end
			lsmr_pkg::ST_CHK_HERE: begin
				here_site_q <= ram_rdata;
				case (mode_q)
					lsmr_pkg::MODE_UPDATE: begin
						res_q <= '{ev: (!site_empty && dies) ? lsmr_pkg::EV_DIED
						                                     : lsmr_pkg::EV_IDLE,
						           site_species: '0, neighbour_species: '0,
						           site_chemicals: '0};
					end
					lsmr_pkg::MODE_READ: begin
						res_q <= '{ev: lsmr_pkg::EV_READ, site_species: ram_rdata.species,
						           neighbour_species: '0, site_chemicals: ram_rdata.chem};
					end
					default: begin
						res_q <= '{ev: lsmr_pkg::EV_IDLE, site_species: ram_rdata.species,
						           neighbour_species: '0, site_chemicals: '0};
					end
				endcase
			end
			lsmr_pkg::ST_EVAL: begin
				here_new_q <= here_new;
				res_q <= '{ev: repro ? lsmr_pkg::EV_REPRO : lsmr_pkg::EV_MOVED,
				           site_species: here_new,
				           neighbour_species: here_site_q.species,
				           site_chemicals: '0};
			end
			default: ;
		endcase
		if (state_q == lsmr_pkg::ST_FIN && out_free) out_q <= res_q;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.ev;
	assign m_axis_tdata  = {out_q.site_chemicals, out_q.neighbour_species, out_q.site_species};

endmodule

// ===== sv/lsmr_chk.sv =====
// Port-level checker for the lattice species unit, bound to the top level.
// Depends on lsmr_pkg and lattice_species_move_reproduce_unit_defines.svh.
`include "lattice_species_move_reproduce_unit_defines.svh"

module lsmr_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [lsmr_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	input logic [lsmr_pkg::EV_W-1:0]       m_axis_tuser
);

	logic                      out_stall, in_fire, out_died, out_repro;
	logic [lsmr_pkg::SP_W-1:0] site_sp, nb_sp;

	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign out_died  = m_axis_tvalid && (m_axis_tuser == lsmr_pkg::EV_DIED);
	assign out_repro = m_axis_tvalid && (m_axis_tuser == lsmr_pkg::EV_REPRO);
	assign site_sp   = m_axis_tdata[3:0];
	assign nb_sp     = m_axis_tdata[7:4];

	// A stalled result holds
	`LSMR_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable({m_axis_tdata, m_axis_tuser}))

	// No result can appear the cycle right after an input transaction
	`LSMR_ASSERT_NEXT(a_no_instant_result, in_fire, !$rose(m_axis_tvalid))

	// A death clears every reported field
	`LSMR_ASSERT_NOW(a_died_zero, out_died, m_axis_tdata == 16'h0000)

	// Reproduction leaves the same nonzero species at both sites
	`LSMR_ASSERT_NOW(a_repro_copy, out_repro, site_sp == nb_sp && site_sp != 4'h0)

endmodule

bind lattice_species_move_reproduce_unit lsmr_chk u_lsmr_chk (.*);
